// ----- design/srtf_pkg.sv -----
`default_nettype none
package srtf_pkg;

	localparam int ARR_W   = 16;
	localparam int BURST_W = 12;
	localparam int RES_W   = 17;
	localparam int SUM_W   = 21;
	localparam int JOBN_W  = 5;

	// one job as read back from the job store
	typedef struct packed {
		logic [ARR_W-1:0]   arr;
		logic [BURST_W-1:0] burst;
		logic [BURST_W-1:0] rem;
	} job_rd_t;

	// outcome of one scan over the job table
	typedef struct packed {
		logic               has_pick;
		logic               has_next;
		logic [BURST_W-1:0] best_rem;
		logic [ARR_W-1:0]   best_arr;
		logic [BURST_W-1:0] best_burst;
		logic [ARR_W-1:0]   next_arr;
	} scan_res_t;

endpackage
`default_nettype wire

// ----- design/srtf_if.sv -----
`default_nettype none
interface srtf_job_if;
	import srtf_pkg::*;

	logic               valid;
	logic               ready;
	logic [ARR_W-1:0]   arrival;
	logic [BURST_W-1:0] burst_length;
	logic               last_job;

	modport source (output valid, arrival, burst_length, last_job, input ready);
	modport sink (input valid, arrival, burst_length, last_job, output ready);
endinterface

interface srtf_res_if;
	import srtf_pkg::*;

	logic              valid;
	logic              ready;
	logic [JOBN_W-1:0] job_number;
	logic [RES_W-1:0]  finish_time;
	logic [RES_W-1:0]  turnaround;
	logic [RES_W-1:0]  wait_res;
	logic [SUM_W-1:0]  wait_sum;
	logic [SUM_W-1:0]  turnaround_sum;
	logic              final_result;

	modport source (output valid, job_number, finish_time, turnaround, wait_res,
		wait_sum, turnaround_sum, final_result, input ready);
	modport sink (input valid, job_number, finish_time, turnaround, wait_res,
		wait_sum, turnaround_sum, final_result, output ready);
endinterface
`default_nettype wire

// ----- design/srtf_jobmem.sv -----
`default_nettype none
module srtf_jobmem #(
	parameter int DEPTH  = 16,
	parameter int IDX_W  = 4,
	parameter int TIME_W = 17
) (
	input  wire                           clk,
	input  wire                           load_we,
	input  wire  [IDX_W-1:0]              load_idx,
	input  wire  [srtf_pkg::ARR_W-1:0]    load_arr,
	input  wire  [srtf_pkg::BURST_W-1:0]  load_burst,
	input  wire                           rem_we,
	input  wire  [IDX_W-1:0]              rem_idx,
	input  wire  [srtf_pkg::BURST_W-1:0]  rem_val,
	input  wire                           fin_we,
	input  wire  [IDX_W-1:0]              fin_idx,
	input  wire  [TIME_W-1:0]             fin_val,
	input  wire  [IDX_W-1:0]              rd_idx,
	output srtf_pkg::job_rd_t             rd_job,
	output logic [TIME_W-1:0]             rd_fin
);
	import srtf_pkg::*;

	logic [ARR_W-1:0]   arr_mem   [DEPTH];
	logic [BURST_W-1:0] burst_mem [DEPTH];
	logic [BURST_W-1:0] rem_mem   [DEPTH];
	logic [TIME_W-1:0]  fin_mem   [DEPTH];

	always_ff @(posedge clk) begin
		if (load_we) begin
			arr_mem[load_idx]   <= load_arr;
			burst_mem[load_idx] <= load_burst;
		end
		if (load_we) begin
			rem_mem[load_idx] <= load_burst;
		end else if (rem_we) begin
			rem_mem[rem_idx] <= rem_val;
		end
		if (fin_we) begin
			fin_mem[fin_idx] <= fin_val;
		end
		rd_job.arr   <= arr_mem[rd_idx];
		rd_job.burst <= burst_mem[rd_idx];
		rd_job.rem   <= rem_mem[rd_idx];
		rd_fin       <= fin_mem[rd_idx];
	end
endmodule
`default_nettype wire

// ----- design/srtf_scan.sv -----
`default_nettype none
module srtf_scan #(
	parameter int IDX_W  = 4,
	parameter int TIME_W = 17
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    clr,
	input  wire                    valid,
	input  wire  [IDX_W-1:0]       idx,
	input  srtf_pkg::job_rd_t      job,
	input  wire  [TIME_W-1:0]      now,
	output srtf_pkg::scan_res_t    res,
	output logic [IDX_W-1:0]       best_idx
);
	import srtf_pkg::*;

	logic               arrived;
	logic               live;
	logic               take_pick;
	logic               take_next;

	logic               has_pick_q;
	logic               has_next_q;
	logic [BURST_W-1:0] best_rem_q;
	logic [ARR_W-1:0]   best_arr_q;
	logic [BURST_W-1:0] best_burst_q;
	logic [ARR_W-1:0]   next_arr_q;

	assign arrived   = TIME_W'(job.arr) <= now;
	assign live      = job.rem != '0;
	// strict less-than keeps the lowest index on ties
	assign take_pick = valid && live && arrived && (!has_pick_q || job.rem < best_rem_q);
	assign take_next = valid && live && !arrived && (!has_next_q || job.arr < next_arr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_pick_q <= 1'b0;
			has_next_q <= 1'b0;
		end else if (clr) begin
			has_pick_q <= 1'b0;
			has_next_q <= 1'b0;
		end else begin
			if (take_pick) has_pick_q <= 1'b1;
			if (take_next) has_next_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_pick) begin
			best_rem_q   <= job.rem;
			best_arr_q   <= job.arr;
			best_burst_q <= job.burst;
			best_idx     <= idx;
		end
		if (take_next) begin
			next_arr_q <= job.arr;
		end
	end

	assign res.has_pick   = has_pick_q;
	assign res.has_next   = has_next_q;
	assign res.best_rem   = best_rem_q;
	assign res.best_arr   = best_arr_q;
	assign res.best_burst = best_burst_q;
	assign res.next_arr   = next_arr_q;
endmodule
`default_nettype wire

// ----- design/shortest_remaining_time_scheduler.sv -----
`default_nettype none
// Channel | Dir | Handshake     | Payload
// jobs    | in  | valid / ready | arrival, burst_length, last_job
// results | out | valid / ready | job_number, finish_time, turnaround, wait_res,
//         |     |               | wait_sum, turnaround_sum, final_result
//
// Loading takes one cycle per job transaction. The job carrying last_job starts the run.
// Each scheduling round is one pass of the shared compare unit over the job store, one
// job per cycle through its registered read port; then S_DEC sets the service slice,
// S_RUN applies it, S_FIN and S_ACC follow when a job completes. Rounds end at an
// arrival, a completion or an idle jump, so a run is at most about 3N rounds. Each
// result passes S_ORD, S_OCALC and S_OSEND, stalling on results. jobs.ready is low
// from last_job until the final result transaction. Reset clears the job count, time,
// sums and sequencer; job storage is left as is since only loaded entries are read.
module shortest_remaining_time_scheduler #(
	parameter int MAX_PROCS = 16
) (
	input wire          clk,
	input wire          arst_n,
	srtf_job_if.sink    jobs,
	srtf_res_if.source  results
);
	import srtf_pkg::*;

	localparam int IDX_W  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int CNT_W  = $clog2(MAX_PROCS + 1);
	// latest possible finish: last arrival plus every burst back to back
	localparam int T_MAX  = (1 << ARR_W) + MAX_PROCS * ((1 << BURST_W) - 1);
	localparam int TIME_W = ($clog2(T_MAX + 1) > RES_W) ? $clog2(T_MAX + 1) : RES_W;

	localparam logic [3:0] S_LOAD  = 4'd0;
	localparam logic [3:0] S_SCAN  = 4'd1;
	localparam logic [3:0] S_DEC   = 4'd2;
	localparam logic [3:0] S_RUN   = 4'd3;
	localparam logic [3:0] S_FIN   = 4'd4;
	localparam logic [3:0] S_ACC   = 4'd5;
	localparam logic [3:0] S_ORD   = 4'd6;
	localparam logic [3:0] S_OCALC = 4'd7;
	localparam logic [3:0] S_OSEND = 4'd8;

	logic [3:0]         st_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   sc_q;
	logic               rd_v_q;
	logic [IDX_W-1:0]   rd_idx_q;
	logic [IDX_W-1:0]   oi_q;
	logic [TIME_W-1:0]  t_q;
	logic [SUM_W-1:0]   wsum_q;
	logic [SUM_W-1:0]   tsum_q;
	logic [BURST_W-1:0] delta_q;
	logic [TIME_W-1:0]  tat_q;

	logic [JOBN_W-1:0]  jobn_q;
	logic [RES_W-1:0]   fin_out_q;
	logic [RES_W-1:0]   tat_out_q;
	logic [RES_W-1:0]   wt_out_q;
	logic [SUM_W-1:0]   wsum_out_q;
	logic [SUM_W-1:0]   tsum_out_q;
	logic               final_q;

	// job store and scan unit hookup
	logic               load_we;
	logic [BURST_W-1:0] load_burst;
	logic               rem_we;
	logic [BURST_W-1:0] new_rem;
	logic               fin_we;
	logic [IDX_W-1:0]   rd_idx;
	job_rd_t            rd_job;
	logic [TIME_W-1:0]  rd_fin;
	logic               scan_clr;
	scan_res_t          sres;
	logic [IDX_W-1:0]   best_idx;

	logic [TIME_W-1:0]  gap;
	logic [IDX_W:0]     oi_next;
	logic               last_out;
	logic [TIME_W-1:0]  o_tat;
	logic [TIME_W-1:0]  o_wt;

	assign jobs.ready = (st_q == S_LOAD);
	assign load_we    = jobs.valid && jobs.ready && (cnt_q < CNT_W'(MAX_PROCS));
	// a zero burst is served as one unit
	assign load_burst = (jobs.burst_length == '0) ? BURST_W'(1) : jobs.burst_length;

	assign new_rem  = sres.best_rem - delta_q;
	assign rem_we   = (st_q == S_RUN);
	assign fin_we   = (st_q == S_FIN);
	assign rd_idx   = (st_q == S_SCAN) ? sc_q[IDX_W-1:0] : oi_q;
	assign scan_clr = (st_q == S_SCAN) && (sc_q == '0);

	// distance to the next arrival; only used when one exists
	assign gap      = TIME_W'(sres.next_arr) - t_q;

	assign oi_next  = (IDX_W+1)'(oi_q) + 1'b1;
	assign last_out = (oi_next == (IDX_W+1)'(cnt_q));
	assign o_tat    = rd_fin - TIME_W'(rd_job.arr);
	assign o_wt     = o_tat - TIME_W'(rd_job.burst);

	srtf_jobmem #(
		.DEPTH  (MAX_PROCS),
		.IDX_W  (IDX_W),
		.TIME_W (TIME_W)
	) u_mem (
		.clk        (clk),
		.load_we    (load_we),
		.load_idx   (cnt_q[IDX_W-1:0]),
		.load_arr   (jobs.arrival),
		.load_burst (load_burst),
		.rem_we     (rem_we),
		.rem_idx    (best_idx),
		.rem_val    (new_rem),
		.fin_we     (fin_we),
		.fin_idx    (best_idx),
		.fin_val    (t_q),
		.rd_idx     (rd_idx),
		.rd_job     (rd_job),
		.rd_fin     (rd_fin)
	);

	srtf_scan #(
		.IDX_W  (IDX_W),
		.TIME_W (TIME_W)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.clr      (scan_clr),
		.valid    (rd_v_q),
		.idx      (rd_idx_q),
		.job      (rd_job),
		.now      (t_q),
		.res      (sres),
		.best_idx (best_idx)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_LOAD;
			cnt_q  <= '0;
			sc_q   <= '0;
			rd_v_q <= 1'b0;
			oi_q   <= '0;
			t_q    <= '0;
			wsum_q <= '0;
			tsum_q <= '0;
		end else begin
			case (st_q)
				S_LOAD: begin
					if (jobs.valid) begin
						if (load_we) cnt_q <= cnt_q + 1'b1;
						if (jobs.last_job) begin
							sc_q <= '0;
							st_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					// issue one read per cycle; data lands in the scan unit next cycle
					if (sc_q != cnt_q) begin
						rd_v_q <= 1'b1;
						sc_q   <= sc_q + 1'b1;
					end else begin
						rd_v_q <= 1'b0;
						if (!rd_v_q) st_q <= S_DEC;
					end
				end
				S_DEC: begin
					sc_q <= '0;
					if (sres.has_pick) begin
						st_q <= S_RUN;
					end else if (sres.has_next) begin
						// CPU idle: jump to the next arrival
						t_q  <= TIME_W'(sres.next_arr);
						st_q <= S_SCAN;
					end else begin
						oi_q <= '0;
						st_q <= S_ORD;
					end
				end
				S_RUN: begin
					t_q  <= t_q + TIME_W'(delta_q);
					st_q <= (new_rem == '0) ? S_FIN : S_SCAN;
				end
				S_FIN: begin
					st_q <= S_ACC;
				end
				S_ACC: begin
					tsum_q <= tsum_q + SUM_W'(tat_q);
					wsum_q <= wsum_q + SUM_W'(tat_q - TIME_W'(sres.best_burst));
					st_q   <= S_SCAN;
				end
				S_ORD: begin
					st_q <= S_OCALC;
				end
				S_OCALC: begin
					st_q <= S_OSEND;
				end
				S_OSEND: begin
					if (results.ready) begin
						if (final_q) begin
							cnt_q  <= '0;
							t_q    <= '0;
							wsum_q <= '0;
							tsum_q <= '0;
							st_q   <= S_LOAD;
						end else begin
							oi_q <= oi_q + 1'b1;
							st_q <= S_ORD;
						end
					end
				end
				default: begin
					st_q <= S_LOAD;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		rd_idx_q <= sc_q[IDX_W-1:0];
		if (st_q == S_DEC) begin
			// serve the pick until it finishes or the next arrival may preempt it
			if (sres.has_next && (gap < TIME_W'(sres.best_rem)))
				delta_q <= gap[BURST_W-1:0];
			else
				delta_q <= sres.best_rem;
		end
		if (st_q == S_FIN) begin
			tat_q <= t_q - TIME_W'(sres.best_arr);
		end
		if (st_q == S_OCALC) begin
			jobn_q     <= JOBN_W'(oi_next);
			fin_out_q  <= rd_fin[RES_W-1:0];
			tat_out_q  <= o_tat[RES_W-1:0];
			wt_out_q   <= o_wt[RES_W-1:0];
			wsum_out_q <= last_out ? wsum_q : '0;
			tsum_out_q <= last_out ? tsum_q : '0;
			final_q    <= last_out;
		end
	end

	assign results.valid          = (st_q == S_OSEND);
	assign results.job_number     = jobn_q;
	assign results.finish_time    = fin_out_q;
	assign results.turnaround     = tat_out_q;
	assign results.wait_res       = wt_out_q;
	assign results.wait_sum       = wsum_out_q;
	assign results.turnaround_sum = tsum_out_q;
	assign results.final_result   = final_q;

endmodule
`default_nettype wire
